### hdl/dhc_pkg.sv
// Shared types, constants and the byte-wise CRC-32 update for the datagram
// header checker.
// No dependencies.
package dhc_pkg;

  // default byte limit of one datagram
  localparam int DHC_MAX_BYTES = 65536;

  // header layout
  localparam int HDR_LEN = 32;

  // crc-32, reflected polynomial
  localparam logic [31:0] CRC_PRESET = 32'hFFFF_FFFF;
  localparam logic [31:0] CRC_POLY   = 32'hEDB8_8320;

  // configuration register indexes
  localparam logic [1:0] REG_MAGIC    = 2'd0;
  localparam logic [1:0] REG_VERSION  = 2'd1;
  localparam logic [1:0] REG_TYPE_LO  = 2'd2;
  localparam logic [1:0] REG_TYPE_HI  = 2'd3;

  // status codes, first failing check wins
  localparam logic [2:0] STAT_OK       = 3'd0;
  localparam logic [2:0] STAT_SHORT    = 3'd1;
  localparam logic [2:0] STAT_MAGIC    = 3'd2;
  localparam logic [2:0] STAT_VERSION  = 3'd3;
  localparam logic [2:0] STAT_LENGTH   = 3'd4;
  localparam logic [2:0] STAT_CHECKSUM = 3'd5;
  localparam logic [2:0] STAT_TYPE     = 3'd6;

  typedef struct packed {
    logic [31:0] magic_value;
    logic [7:0]  version_value;
    logic [7:0]  type_lowest;
    logic [7:0]  type_highest;
  } cfg_t;

  typedef struct packed {
    logic [7:0]  payload_byte;
    logic        payload_valid;
    logic        done_res;
    logic [2:0]  status;
    logic [7:0]  packet_kind;
    logic [15:0] flag_bits;
    logic [31:0] session_word;
    logic [31:0] sequence_word;
    logic [31:0] ack_word;
    logic [15:0] payload_count;
  } res_t;

  // one byte through the reflected crc, lsb first
  function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input logic [7:0] b);
    logic [31:0] c;
    c = c_in ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
    end
    return c;
  endfunction

endpackage

### hdl/datagram_header_checker.sv
// Top level of the datagram header checker: configuration registers, the
// datagram parser and the result buffer.
// Depends on dhc_pkg, dhc_parse and dhc_out_buf.
//
// Usage:
//   Bytes of a datagram enter on in_byte with in_last on the final byte,
//   one request per in_valid/in_ready handshake. Header bytes (offsets 0 to
//   31) that are not final give no result. Each payload byte gives one
//   result with payload_valid set; the final byte gives one result with
//   done_res set, the decoded header fields, payload_count and status.
//   A result is registered in the result buffer and shows on out_valid
//   once the buffer's output register is free. Throughput is one byte per
//   cycle while in_ready is high, set by the byte-wide crc update and
//   checks between the datagram state and the result buffer.
//   Reset clears the datagram state and the result buffer and loads the
//   register defaults (magic 0, version 1, type range 0 to 4).
//   When out_ready is low the result is held; one more result goes to the
//   skid register, after which in_ready drops until the receiver drains.
//   Configuration writes (cfg_we, cfg_index, cfg_data) take effect at once;
//   the user makes them between datagrams, which the block does not enforce.
module datagram_header_checker
  import dhc_pkg::*;
#(
  parameter int MAX_BYTES = DHC_MAX_BYTES
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  payload_byte,
  output logic        payload_valid,
  output logic        done_res,
  output logic [2:0]  status,
  output logic [7:0]  packet_kind,
  output logic [15:0] flag_bits,
  output logic [31:0] session_word,
  output logic [31:0] sequence_word,
  output logic [31:0] ack_word,
  output logic [15:0] payload_count
);

  cfg_t cfg;
  logic take;
  logic emit;
  logic space;
  res_t res;
  res_t out_data;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.magic_value   <= 32'd0;
      cfg.version_value <= 8'd1;
      cfg.type_lowest   <= 8'd0;
      cfg.type_highest  <= 8'd4;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MAGIC:   cfg.magic_value   <= cfg_data;
        REG_VERSION: cfg.version_value <= cfg_data[7:0];
        REG_TYPE_LO: cfg.type_lowest   <= cfg_data[7:0];
        REG_TYPE_HI: cfg.type_highest  <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  assign in_ready = space;
  assign take = in_valid && in_ready;

  dhc_parse #(
    .MAX_BYTES(MAX_BYTES)
  ) u_parse (
    .clk(clk),
    .rst(rst),
    .cfg(cfg),
    .take(take),
    .in_byte(in_byte),
    .in_last(in_last),
    .emit(emit),
    .res(res)
  );

  dhc_out_buf u_out_buf (
    .clk(clk),
    .rst(rst),
    .push(take && emit),
    .push_data(res),
    .space(space),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data)
  );

  // result fields
  assign payload_byte  = out_data.payload_byte;
  assign payload_valid = out_data.payload_valid;
  assign done_res      = out_data.done_res;
  assign status        = out_data.status;
  assign packet_kind   = out_data.packet_kind;
  assign flag_bits     = out_data.flag_bits;
  assign session_word  = out_data.session_word;
  assign sequence_word = out_data.sequence_word;
  assign ack_word      = out_data.ack_word;
  assign payload_count = out_data.payload_count;

endmodule

### hdl/dhc_parse.sv
// Datagram state: byte counter, header capture, running crc and the
// end-of-datagram checks. Builds one result per payload or final byte.
// Depends on dhc_pkg.
module dhc_parse
  import dhc_pkg::*;
#(
  parameter int MAX_BYTES = DHC_MAX_BYTES
) (
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       cfg,
  input  logic       take,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       emit,
  output res_t       res
);

  localparam int CNT_W = $clog2(MAX_BYTES + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_BYTES);
  localparam logic [CNT_W-1:0] CNT_HDR = CNT_W'(HDR_LEN);

  logic [CNT_W-1:0] byte_count, byte_count_next;
  logic [31:0] crc_reg, crc_reg_next;
  logic [31:0] magic_seen, magic_seen_next;
  logic [7:0]  version_seen, version_seen_next;
  logic [7:0]  kind_seen, kind_seen_next;
  logic [15:0] flags_seen, flags_seen_next;
  logic [31:0] session_seen, session_seen_next;
  logic [31:0] sequence_seen, sequence_seen_next;
  logic [31:0] ack_seen, ack_seen_next;
  logic [31:0] length_seen, length_seen_next;
  logic [31:0] crc_expected, crc_expected_next;
  logic        too_long, too_long_next;

  logic        is_payload;
  logic [4:0]  off;
  logic [1:0]  pos;
  logic [7:0]  crc_in;
  logic [CNT_W-1:0] pay;
  logic [31:0] pay32;
  logic [2:0]  stat;

  assign is_payload = (byte_count >= CNT_HDR);
  assign off = byte_count[4:0];
  assign pos = off[1:0];

  // header capture, big-endian within each field
  always_comb begin
    magic_seen_next    = magic_seen;
    version_seen_next  = version_seen;
    kind_seen_next     = kind_seen;
    flags_seen_next    = flags_seen;
    session_seen_next  = session_seen;
    sequence_seen_next = sequence_seen;
    ack_seen_next      = ack_seen;
    length_seen_next   = length_seen;
    crc_expected_next  = crc_expected;
    if (!is_payload) begin
      case (off[4:2])
        3'd0: magic_seen_next[8*(3-pos) +: 8] = in_byte;
        3'd1: begin
          case (pos)
            2'd0: version_seen_next = in_byte;
            2'd1: kind_seen_next = in_byte;
            2'd2: flags_seen_next[15:8] = in_byte;
            default: flags_seen_next[7:0] = in_byte;
          endcase
        end
        3'd2: session_seen_next[8*(3-pos) +: 8] = in_byte;
        3'd3: sequence_seen_next[8*(3-pos) +: 8] = in_byte;
        3'd4: ack_seen_next[8*(3-pos) +: 8] = in_byte;
        3'd5: length_seen_next[8*(3-pos) +: 8] = in_byte;
        3'd6: crc_expected_next[8*(3-pos) +: 8] = in_byte;
        default: ;
      endcase
    end
  end

  // stored crc bytes enter the crc as zero
  assign crc_in = (!is_payload && off[4:2] == 3'd6) ? 8'd0 : in_byte;
  assign crc_reg_next = crc_byte(crc_reg, crc_in);

  // saturating counter, overlong flag
  assign byte_count_next = (byte_count >= CNT_MAX) ? byte_count : byte_count + 1'b1;
  assign too_long_next = too_long | (byte_count >= CNT_MAX);

  assign pay = (byte_count_next > CNT_HDR) ? byte_count_next - CNT_HDR : '0;
  assign pay32 = 32'(pay);

  // end-of-datagram checks in priority order
  always_comb begin
    if (byte_count_next < CNT_HDR) begin
      stat = STAT_SHORT;
    end else if (magic_seen_next != cfg.magic_value) begin
      stat = STAT_MAGIC;
    end else if (version_seen_next != cfg.version_value) begin
      stat = STAT_VERSION;
    end else if (too_long_next || length_seen_next != pay32) begin
      stat = STAT_LENGTH;
    end else if (~crc_reg_next != crc_expected_next) begin
      stat = STAT_CHECKSUM;
    end else if (kind_seen_next < cfg.type_lowest || kind_seen_next > cfg.type_highest) begin
      stat = STAT_TYPE;
    end else begin
      stat = STAT_OK;
    end
  end

  // result for this byte
  assign emit = is_payload | in_last;
  always_comb begin
    res = '0;
    if (is_payload) begin
      res.payload_byte  = in_byte;
      res.payload_valid = 1'b1;
    end
    if (in_last) begin
      res.done_res      = 1'b1;
      res.status        = stat;
      res.packet_kind   = kind_seen_next;
      res.flag_bits     = flags_seen_next;
      res.session_word  = session_seen_next;
      res.sequence_word = sequence_seen_next;
      res.ack_word      = ack_seen_next;
      res.payload_count = (pay32 > 32'h0000_FFFF) ? 16'hFFFF : pay32[15:0];
    end
  end

  // datagram state, cleared after each final byte
  always_ff @(posedge clk) begin
    if (rst || (take && in_last)) begin
      byte_count    <= '0;
      crc_reg       <= CRC_PRESET;
      magic_seen    <= '0;
      version_seen  <= '0;
      kind_seen     <= '0;
      flags_seen    <= '0;
      session_seen  <= '0;
      sequence_seen <= '0;
      ack_seen      <= '0;
      length_seen   <= '0;
      crc_expected  <= '0;
      too_long      <= 1'b0;
    end else if (take) begin
      byte_count    <= byte_count_next;
      crc_reg       <= crc_reg_next;
      magic_seen    <= magic_seen_next;
      version_seen  <= version_seen_next;
      kind_seen     <= kind_seen_next;
      flags_seen    <= flags_seen_next;
      session_seen  <= session_seen_next;
      sequence_seen <= sequence_seen_next;
      ack_seen      <= ack_seen_next;
      length_seen   <= length_seen_next;
      crc_expected  <= crc_expected_next;
      too_long      <= too_long_next;
    end
  end

endmodule

### hdl/dhc_out_buf.sv
// Two-entry result buffer: output register plus a skid register, so the
// input side keeps moving for one request while the receiver stalls.
// Depends on dhc_pkg.
module dhc_out_buf
  import dhc_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  res_t push_data,
  output logic space,
  output logic out_valid,
  input  logic out_ready,
  output res_t out_data
);

  logic skid_valid;
  res_t skid_data;

  assign space = !skid_valid;

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_valid && !out_ready) begin
      if (push) begin
        skid_valid <= 1'b1;
      end
    end else if (skid_valid) begin
      out_valid  <= 1'b1;
      skid_valid <= 1'b0;
    end else begin
      out_valid <= push;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (out_valid && !out_ready) begin
      if (push) begin
        skid_data <= push_data;
      end
    end else if (skid_valid) begin
      out_data <= skid_data;
    end else if (push) begin
      out_data <= push_data;
    end
  end

endmodule

### hdl/dhc_checker.sv
// Port-level checks for the datagram header checker, bound to the top level.
// Depends on dhc_pkg and datagram_header_checker.
module dhc_checker
  import dhc_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic        payload_valid,
  input logic        done_res,
  input logic [2:0]  status,
  input logic [15:0] payload_count,
  input logic [7:0]  payload_byte
);

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(payload_byte))
    else $error("stalled result changed");

  // every result carries a payload byte or closes a datagram
  a_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> payload_valid || done_res)
    else $error("empty result");

  // summary fields are zero off the final result
  a_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !done_res |-> status == STAT_OK && payload_count == 16'd0)
    else $error("summary on a payload-only result");

  // nothing comes out right after reset
  a_rst: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("result after reset");

endmodule

bind datagram_header_checker dhc_checker u_dhc_checker (.*);
